// ----- sv/rdse_pkg.sv -----
// ----------------------------------------------------------------------------
// rdse_pkg
// Shared types and constants of the reference delta series encoder: result
// kind codes, configuration register indexes, code word limits and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rdse_pkg;

  localparam int CODE_BITS = 17;
  localparam logic [CODE_BITS-1:0] CODE_MAX = 17'h1FFFF;

  localparam int CFG_DATA_BITS = 16;
  localparam int LEN_BITS      = 7;
  localparam logic [LEN_BITS-1:0] LEN_RESET = 7'd64;

  localparam logic REG_SERIES_LENGTH = 1'b0;
  localparam logic REG_OFFSET_VALUE  = 1'b1;

  localparam logic [1:0] KIND_FIXED     = 2'd0;
  localparam logic [1:0] KIND_REFERENCE = 2'd1;
  localparam logic [1:0] KIND_DERIVED   = 2'd2;

  typedef struct packed {
    logic       write_cell;
    logic       read_mem;
    logic       load_out;
    logic       write_ref;
    logic       first_word;
    logic       last_word;
    logic [1:0] kind;
  } rdse_cmd_t;

  typedef struct packed {
    logic out_free;
    logic match_prev;
  } rdse_status_t;

endpackage

// ----- sv/rdse_ctrl.sv -----
// ----------------------------------------------------------------------------
// rdse_ctrl
// Controller: collects a series, classifies it, then walks the stored
// samples one word at a time into the datapath's output register.
// ----------------------------------------------------------------------------
module rdse_ctrl #(
  parameter int MAX_SERIES = 64
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  group_start,
  input  logic [$clog2(MAX_SERIES+1)-1:0]       len,
  input  rdse_pkg::rdse_status_t                status,
  output rdse_pkg::rdse_cmd_t                   cmd,
  output logic [$clog2(MAX_SERIES)-1:0]         wr_addr,
  output logic [$clog2(MAX_SERIES)-1:0]         rd_addr
);

  localparam int IDX_W = $clog2(MAX_SERIES);
  localparam int CNT_W = $clog2(MAX_SERIES + 1);

  typedef enum logic [2:0] {
    ST_COLLECT = 3'b001,
    ST_READ    = 3'b010,
    ST_LOAD    = 3'b100
  } state_t;

  state_t           state;
  logic [IDX_W-1:0] sample_index;
  logic [IDX_W-1:0] rd_index;
  logic [CNT_W-1:0] total;
  logic [1:0]       kind;
  logic             all_equal;
  logic             have_reference;

  logic             in_fire;
  logic [CNT_W-1:0] count_next;
  logic             series_done;
  logic             all_equal_next;
  logic             have_ref_next;
  logic             last_word;

  assign in_stall       = (state != ST_COLLECT);
  assign in_fire        = in_valid && !in_stall;
  assign count_next     = CNT_W'(sample_index) + CNT_W'(1);
  assign series_done    = (count_next >= len);
  assign all_equal_next = (sample_index == '0) || (all_equal && status.match_prev);
  assign have_ref_next  = have_reference && !group_start;
  assign last_word      = ((CNT_W'(rd_index) + CNT_W'(1)) == total);

  assign wr_addr = sample_index;
  assign rd_addr = rd_index;

  always_comb begin
    cmd            = '0;
    cmd.write_cell = in_fire;
    cmd.read_mem   = (state == ST_READ);
    cmd.load_out   = (state == ST_LOAD) && status.out_free;
    cmd.write_ref  = cmd.load_out && (kind == rdse_pkg::KIND_REFERENCE);
    cmd.first_word = (rd_index == '0);
    cmd.last_word  = last_word;
    cmd.kind       = kind;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_COLLECT;
      sample_index   <= '0;
      rd_index       <= '0;
      total          <= '0;
      kind           <= rdse_pkg::KIND_FIXED;
      all_equal      <= 1'b1;
      have_reference <= 1'b0;
    end else begin
      case (state)
        ST_COLLECT: begin
          if (in_fire) begin
            all_equal <= all_equal_next;
            if (series_done) begin
              sample_index <= '0;
              rd_index     <= '0;
              state        <= ST_READ;
              if (all_equal_next) begin
                kind           <= rdse_pkg::KIND_FIXED;
                total          <= CNT_W'(1);
                have_reference <= have_ref_next;
              end else if (!have_ref_next) begin
                kind           <= rdse_pkg::KIND_REFERENCE;
                total          <= count_next;
                have_reference <= 1'b1;
              end else begin
                kind           <= rdse_pkg::KIND_DERIVED;
                total          <= count_next;
                have_reference <= 1'b1;
              end
            end else begin
              // count_next < len <= MAX_SERIES here, so it fits the index
              sample_index   <= count_next[IDX_W-1:0];
              have_reference <= have_ref_next;
            end
          end
        end
        ST_READ: begin
          state <= ST_LOAD;
        end
        ST_LOAD: begin
          if (status.out_free) begin
            if (last_word) begin
              state <= ST_COLLECT;
            end else begin
              rd_index <= rd_index + IDX_W'(1);
              state    <= ST_READ;
            end
          end
        end
        default: begin
          state <= ST_COLLECT;
        end
      endcase
    end
  end

  a_last_returns: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_out && cmd.last_word) |=> (state == ST_COLLECT))
    else $error("last word did not return controller to collect");

  a_read_then_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |=> (state == ST_LOAD))
    else $error("memory read not followed by load");

  a_index_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOAD) |-> ((CNT_W'(rd_index) + CNT_W'(1)) <= total))
    else $error("word index beyond cell length");

  a_fixed_single: assert property (@(posedge clk) disable iff (rst)
    ((state != ST_COLLECT) && (kind == rdse_pkg::KIND_FIXED)) |-> (total == CNT_W'(1)))
    else $error("fixed series with more than one word");

endmodule

// ----- sv/rdse_datapath.sv -----
// ----------------------------------------------------------------------------
// rdse_datapath
// Datapath: configuration registers, sample and reference memories, the
// offset / zigzag code unit and the output register.
// ----------------------------------------------------------------------------
module rdse_datapath #(
  parameter int MAX_SERIES  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        cfg_valid,
  output logic                                        cfg_ready,
  input  logic                                        cfg_index,
  input  logic [rdse_pkg::CFG_DATA_BITS-1:0]          cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]               sample,
  input  rdse_pkg::rdse_cmd_t                         cmd,
  input  logic [$clog2(MAX_SERIES)-1:0]               wr_addr,
  input  logic [$clog2(MAX_SERIES)-1:0]               rd_addr,
  output rdse_pkg::rdse_status_t                      status,
  output logic [$clog2(MAX_SERIES+1)-1:0]             len,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic [1:0]                                  cell_kind,
  output logic [rdse_pkg::CODE_BITS-1:0]              code_word,
  output logic                                        last_of_cell
);

  localparam int CNT_W = $clog2(MAX_SERIES + 1);
  localparam int OFF_W = ((SAMPLE_BITS > 16) ? SAMPLE_BITS : 16) + 1;
  localparam int DIF_W = SAMPLE_BITS + 1;
  localparam int ZZ_W  = SAMPLE_BITS + 2;
  localparam int CMP_W = (ZZ_W > rdse_pkg::CODE_BITS) ? ZZ_W : rdse_pkg::CODE_BITS;
  localparam logic [rdse_pkg::LEN_BITS-1:0] LEN_MAX = rdse_pkg::LEN_BITS'(MAX_SERIES);

  logic [rdse_pkg::LEN_BITS-1:0]             series_length;
  logic signed [rdse_pkg::CFG_DATA_BITS-1:0] offset_value;

  logic signed [SAMPLE_BITS-1:0] cell_mem [MAX_SERIES];
  logic signed [SAMPLE_BITS-1:0] ref_mem  [MAX_SERIES];
  logic signed [SAMPLE_BITS-1:0] last_sample;
  logic signed [SAMPLE_BITS-1:0] cell_q;
  logic signed [SAMPLE_BITS-1:0] ref_q;
  logic signed [SAMPLE_BITS-1:0] prev_q;

  logic signed [OFF_W-1:0]           off_diff;
  logic signed [SAMPLE_BITS-1:0]     dif_base;
  logic signed [DIF_W-1:0]           dif;
  logic [ZZ_W-1:0]                   zz;
  logic                              use_off;
  logic [CMP_W-1:0]                  raw;
  logic [rdse_pkg::CODE_BITS-1:0]    code;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_length <= rdse_pkg::LEN_RESET;
      offset_value  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rdse_pkg::REG_SERIES_LENGTH: series_length <= cfg_data[rdse_pkg::LEN_BITS-1:0];
        rdse_pkg::REG_OFFSET_VALUE:  offset_value  <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // zero acts as one, anything past the buffer depth as the depth
  always_comb begin
    if (series_length == '0) begin
      len = CNT_W'(1);
    end else if (series_length > LEN_MAX) begin
      len = CNT_W'(MAX_SERIES);
    end else begin
      len = CNT_W'(series_length);
    end
  end

  assign status.match_prev = (sample == last_sample);
  assign status.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.write_cell) begin
      cell_mem[wr_addr] <= sample;
      last_sample       <= sample;
    end
    if (cmd.read_mem) begin
      cell_q <= cell_mem[rd_addr];
      ref_q  <= ref_mem[rd_addr];
    end
    if (cmd.write_ref) begin
      ref_mem[rd_addr] <= cell_q;
    end
    if (cmd.load_out) begin
      prev_q <= cell_q;
    end
  end

  always_comb begin
    use_off  = (cmd.kind == rdse_pkg::KIND_FIXED) ||
               ((cmd.kind == rdse_pkg::KIND_REFERENCE) && cmd.first_word);
    off_diff = OFF_W'(cell_q) - OFF_W'(offset_value);
    dif_base = (cmd.kind == rdse_pkg::KIND_DERIVED) ? ref_q : prev_q;
    dif      = DIF_W'(cell_q) - DIF_W'(dif_base);
    zz       = {dif, 1'b0} ^ {ZZ_W{dif[DIF_W-1]}};
    if (use_off) begin
      raw = off_diff[OFF_W-1] ? '0 : CMP_W'($unsigned(off_diff));
    end else begin
      raw = CMP_W'(zz);
    end
    code = (raw > CMP_W'(rdse_pkg::CODE_MAX)) ? rdse_pkg::CODE_MAX
                                              : raw[rdse_pkg::CODE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      cell_kind    <= cmd.kind;
      code_word    <= code;
      last_of_cell <= cmd.last_word;
    end
  end

endmodule

// ----- sv/reference_delta_series_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// reference_delta_series_encoder_unit
// Encodes each cell's time series as a fixed value, a group reference
// (offset first value plus zigzag step deltas) or zigzag deltas against
// the stored reference.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one sample per beat, group_start
//   high on the first sample of a new group. The block takes one sample a
//   cycle while collecting a series of series_length samples.
//   Output channel (out_valid / out_stall): one code word per beat, with
//   last_of_cell on the final word of a cell.
//   Config channel (cfg_valid / cfg_ready, always ready): index 0 is
//   series_length, index 1 is offset_value; write only while idle.
//   Walk: after the last sample's beat, each word of the cell goes through a
//   registered read of the sample and reference memories (ST_READ), then
//   the code unit into the output register (ST_LOAD); in_stall is high for
//   the whole walk, so no new sample is taken until the cell is out.
//   The next series' first sample is taken while the final word still
//   waits. A stalled receiver holds the output register and the walk pauses.
//   Reset sets series_length to 64, offset_value to 0 and drops the stored
//   reference; the memories are not cleared.
// ----------------------------------------------------------------------------
module reference_delta_series_encoder_unit #(
  parameter int MAX_SERIES  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [SAMPLE_BITS-1:0]      sample,
  input  logic                               group_start,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         cell_kind,
  output logic [rdse_pkg::CODE_BITS-1:0]     code_word,
  output logic                               last_of_cell,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic                               cfg_index,
  input  logic [rdse_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  rdse_pkg::rdse_cmd_t                  cmd;
  rdse_pkg::rdse_status_t               status;
  logic [$clog2(MAX_SERIES)-1:0]        wr_addr;
  logic [$clog2(MAX_SERIES)-1:0]        rd_addr;
  logic [$clog2(MAX_SERIES+1)-1:0]      len;

  rdse_ctrl #(
    .MAX_SERIES (MAX_SERIES)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .group_start (group_start),
    .len         (len),
    .status      (status),
    .cmd         (cmd),
    .wr_addr     (wr_addr),
    .rd_addr     (rd_addr)
  );

  rdse_datapath #(
    .MAX_SERIES  (MAX_SERIES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .cmd          (cmd),
    .wr_addr      (wr_addr),
    .rd_addr      (rd_addr),
    .status       (status),
    .len          (len),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cell_kind    (cell_kind),
    .code_word    (code_word),
    .last_of_cell (last_of_cell)
  );

endmodule

// ----- verif/reference_delta_series_encoder_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reference_delta_series_encoder_unit_tb
// Drives sample series of many lengths and offsets through the encoder.
// Random input gaps and output stalls are applied. A sample-level model of the
// fixed/reference/derived classification predicts every code word, and each
// output beat is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module reference_delta_series_encoder_unit_tb;

  localparam int MAX_CELLS  = 64;
  localparam int SAMPLE_W   = 16;
  localparam int CODE_W     = rdse_pkg::CODE_BITS;
  localparam int LEN_W      = rdse_pkg::LEN_BITS;
  localparam int CFG_W      = rdse_pkg::CFG_DATA_BITS;
  localparam int CODE_TOP   = int'(rdse_pkg::CODE_MAX);
  localparam int CYCLE_CAP  = 400000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'h7FFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'h8000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] value;
    logic                       group_start;
  } sample_beat_t;

  typedef struct {
    logic [1:0]        kind;
    logic [CODE_W-1:0] code;
    logic              last;
  } code_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic group_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] cell_kind;
  logic [CODE_W-1:0] code_word;
  logic last_of_cell;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [CFG_W-1:0] cfg_data = '0;

  reference_delta_series_encoder_unit #(
    .MAX_SERIES (MAX_CELLS),
    .SAMPLE_BITS(SAMPLE_W)
  ) u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .group_start (group_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cell_kind   (cell_kind),
    .code_word   (code_word),
    .last_of_cell(last_of_cell),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  sample_beat_t pending_samples[$];
  code_beat_t   expected_words[$];
  int           items_queued = 0;
  int           items_taken  = 0;
  int           err_count    = 0;
  int unsigned  cycle_count  = 0;
  bit           steady       = 1'b0;

  // --------------------------------------------------------------------------
  // Encoder model, advanced on every accepted sample beat
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]           mdl_len = rdse_pkg::LEN_RESET;
  logic signed [SAMPLE_W-1:0] mdl_offset = '0;
  logic signed [SAMPLE_W-1:0] mdl_cell[MAX_CELLS];
  logic signed [SAMPLE_W-1:0] mdl_ref[MAX_CELLS];
  bit                         mdl_have_ref = 1'b0;
  int                         mdl_idx = 0;
  bit                         mdl_all_eq = 1'b1;

  function automatic logic [CODE_W-1:0] zigzag(input int d);
    longint z;
    z = (d >= 0) ? 2 * longint'(d) : -2 * longint'(d) - 1;
    if (z > CODE_TOP) z = CODE_TOP;
    return CODE_W'(z);
  endfunction

  function automatic logic [CODE_W-1:0] offset_code(input logic signed [SAMPLE_W-1:0] v);
    int r;
    r = int'(v) - int'(mdl_offset);
    if (r < 0) r = 0;
    if (r > CODE_TOP) r = CODE_TOP;
    return CODE_W'(r);
  endfunction

  function automatic void push_word(input logic [1:0] kind, input logic [CODE_W-1:0] code,
                                    input logic last);
    code_beat_t w;
    w.kind = kind;
    w.code = code;
    w.last = last;
    expected_words.insert(expected_words.size(), w);
  endfunction

  function automatic void encode_sample(input logic signed [SAMPLE_W-1:0] s, input logic gs);
    int len;
    int n;
    if (gs) mdl_have_ref = 1'b0;
    len = int'(mdl_len);
    if (len < 1) len = 1;
    if (len > MAX_CELLS) len = MAX_CELLS;
    if (mdl_idx >= MAX_CELLS) mdl_idx = 0;
    if (mdl_idx == 0) mdl_all_eq = 1'b1;
    else if (s != mdl_cell[mdl_idx-1]) mdl_all_eq = 1'b0;
    mdl_cell[mdl_idx] = s;
    n = mdl_idx + 1;
    if (n < len) begin
      mdl_idx = n;
      return;
    end
    mdl_idx = 0;
    if (mdl_all_eq) begin
      push_word(rdse_pkg::KIND_FIXED, offset_code(mdl_cell[0]), 1'b1);
    end else if (!mdl_have_ref) begin
      for (int k = 0; k < n; k++) mdl_ref[k] = mdl_cell[k];
      mdl_have_ref = 1'b1;
      push_word(rdse_pkg::KIND_REFERENCE, offset_code(mdl_cell[0]), n == 1);
      for (int k = 1; k < n; k++)
        push_word(rdse_pkg::KIND_REFERENCE,
                  zigzag(int'(mdl_cell[k]) - int'(mdl_cell[k-1])), k + 1 == n);
    end else begin
      for (int k = 0; k < n; k++)
        push_word(rdse_pkg::KIND_DERIVED,
                  zigzag(int'(mdl_cell[k]) - int'(mdl_ref[k])), k + 1 == n);
    end
  endfunction

  // --------------------------------------------------------------------------
  // Sample driver and receiver backpressure
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : drive
    sample_beat_t nb;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_samples.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
        nb = pending_samples.pop_front();
        in_valid    <= 1'b1;
        sample      <= nb.value;
        group_start <= nb.group_start;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(99) < 11);
  end

  // --------------------------------------------------------------------------
  // Monitor: check code words, feed the model, track register writes
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    code_beat_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_words.size() == 0) begin
          $error("unexpected beat: cell_kind %0d code_word %0d last_of_cell %0b",
                 cell_kind, code_word, last_of_cell);
          err_count++;
        end else begin
          want = expected_words.pop_front();
          if (cell_kind !== want.kind) begin
            $error("cell_kind: expected %0d, got %0d", want.kind, cell_kind);
            err_count++;
          end
          if (code_word !== want.code) begin
            $error("code_word: expected %0d, got %0d", want.code, code_word);
            err_count++;
          end
          if (last_of_cell !== want.last) begin
            $error("last_of_cell: expected %0b, got %0b", want.last, last_of_cell);
            err_count++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        items_taken++;
        encode_sample(sample, group_start);
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == rdse_pkg::REG_SERIES_LENGTH) mdl_len = cfg_data[LEN_W-1:0];
        else if (cfg_index == rdse_pkg::REG_OFFSET_VALUE) mdl_offset = cfg_data;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("reference_delta_series_encoder_unit_tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus planning. Mirrors the series bookkeeping so that a derived cell
  // never runs past the reference entries written so far.
  // --------------------------------------------------------------------------
  int                         plan_len = MAX_CELLS;
  int                         plan_idx = 0;
  bit                         plan_have_ref = 1'b0;
  int                         plan_ref_written = 0;
  bit                         plan_all_eq = 1'b1;
  logic signed [SAMPLE_W-1:0] plan_prev = '0;
  logic signed [SAMPLE_W-1:0] plan_cell[MAX_CELLS];
  logic signed [SAMPLE_W-1:0] plan_ref[MAX_CELLS];

  function automatic logic signed [SAMPLE_W-1:0] sat16(input int x);
    if (x > 32767) return S_MAX;
    if (x < -32768) return S_MIN;
    return SAMPLE_W'(x);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] any_sample();
    case ($urandom_range(7))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic void push_item(input logic signed [SAMPLE_W-1:0] v, input logic gs_in);
    sample_beat_t b;
    logic gs;
    int n;
    gs = gs_in;
    if (gs) plan_have_ref = 1'b0;
    if (plan_idx == 0) plan_all_eq = 1'b1;
    else if (v != plan_prev) plan_all_eq = 1'b0;
    plan_prev = v;
    plan_cell[plan_idx] = v;
    n = plan_idx + 1;
    if (n >= plan_len) begin
      // would read reference entries never written: restart the group instead
      if (!plan_all_eq && plan_have_ref && n > plan_ref_written) begin
        gs = 1'b1;
        plan_have_ref = 1'b0;
      end
      if (!plan_all_eq && !plan_have_ref) begin
        for (int k = 0; k < n; k++) plan_ref[k] = plan_cell[k];
        plan_have_ref = 1'b1;
        if (n > plan_ref_written) plan_ref_written = n;
      end
      plan_idx = 0;
    end else begin
      plan_idx = n;
    end
    b.value = v;
    b.group_start = gs;
    pending_samples.insert(pending_samples.size(), b);
    items_queued++;
  endfunction

  task automatic settle();
    while (items_taken != items_queued || expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == rdse_pkg::REG_SERIES_LENGTH) begin
      plan_len = int'(data[LEN_W-1:0]);
      if (plan_len < 1) plan_len = 1;
      if (plan_len > MAX_CELLS) plan_len = MAX_CELLS;
    end
  endtask

  task automatic gen_series(input int count);
    int style;
    logic signed [SAMPLE_W-1:0] base;
    logic signed [SAMPLE_W-1:0] v;
    logic gs;
    style = $urandom_range(99);
    base  = any_sample();
    for (int k = 0; k < count; k++) begin
      gs = (plan_idx == 0) ? ($urandom_range(7) == 0) : ($urandom_range(39) == 0);
      if (style < 20) begin
        v = (plan_idx == 0) ? base : plan_prev;
      end else if (style < 55) begin
        // close to the stored reference, so derived words stay small
        if (plan_idx < plan_ref_written)
          v = sat16(int'(plan_ref[plan_idx]) + int'($urandom_range(16)) - 8);
        else
          v = any_sample();
      end else if (style < 75) begin
        v = any_sample();
      end else if (style < 90) begin
        v = (plan_idx == 0) ? base : sat16(int'(plan_prev) + int'($urandom_range(600)) - 300);
      end else begin
        v = $urandom_range(1) ? S_MAX : S_MIN;
      end
      push_item(v, gs);
    end
  endtask

  logic [LEN_W-1:0] phase_len[16] = '{7'd3, 7'd2, 7'd5, 7'd0, 7'd4, 7'd8, 7'd127, 7'd6,
                                      7'd1, 7'd16, 7'd3, 7'd64, 7'd7, 7'd2, 7'd4, 7'd5};

  initial begin : stimulus
    int quota;
    int pushed;
    logic [CFG_W-1:0] off;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    write_reg(rdse_pkg::REG_SERIES_LENGTH, 16'd4);
    write_reg(rdse_pkg::REG_OFFSET_VALUE, 16'd0);
    for (int k = 0; k < 4; k++) push_item(S_MAX, k == 0);
    // alternating extremes become the reference; first value clamps to zero
    push_item(S_MIN, 1'b0); push_item(S_MAX, 1'b0); push_item(S_MIN, 1'b0); push_item(S_MAX, 1'b0);
    // full-swing differences against the reference
    push_item(S_MAX, 1'b0); push_item(S_MIN, 1'b0); push_item(S_MAX, 1'b0); push_item(S_MIN, 1'b0);
    for (int k = 0; k < 4; k++) push_item(S_MIN, 1'b0);
    // group start on the third sample: judged without a reference
    push_item(16'sd0, 1'b0); push_item(16'sd1, 1'b0); push_item(16'sd2, 1'b1);
    push_item(16'sd3, 1'b0);
    // shorten the series while three samples are held
    push_item(16'sd5, 1'b0); push_item(16'sd6, 1'b0); push_item(16'sd7, 1'b0);
    write_reg(rdse_pkg::REG_SERIES_LENGTH, 16'd2);
    push_item(16'sd9, 1'b0);
    write_reg(rdse_pkg::REG_OFFSET_VALUE, 16'h8000);
    push_item(S_MAX, 1'b0); push_item(S_MAX, 1'b0);
    write_reg(rdse_pkg::REG_OFFSET_VALUE, 16'h7FFF);
    push_item(S_MIN, 1'b0); push_item(S_MIN, 1'b0);
    write_reg(rdse_pkg::REG_SERIES_LENGTH, 16'd0);
    push_item(16'sd100, 1'b0);

    // random part, one setting of both registers per phase
    for (int ph = 0; ph < 16; ph++) begin
      write_reg(rdse_pkg::REG_SERIES_LENGTH, {9'($urandom_range(511)), phase_len[ph]});
      case ($urandom_range(4))
        0: off = 16'h0000;
        1: off = 16'h8000;
        2: off = 16'h7FFF;
        3: off = 16'($urandom_range(200)) - 16'd100;
        default: off = 16'($urandom);
      endcase
      write_reg(rdse_pkg::REG_OFFSET_VALUE, off);
      steady = (ph == 4);
      quota  = 8;
      pushed = 0;
      while (pushed < quota) begin
        gen_series(plan_len - plan_idx);
        pushed += plan_len;
      end
      // sometimes leave a series half done across the next register write
      if (plan_len > 1 && $urandom_range(2) == 0) gen_series($urandom_range(plan_len - 1, 1));
    end

    settle();
    steady = 1'b0;
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("reference_delta_series_encoder_unit_tb: PASS");
    end else begin
      $display("reference_delta_series_encoder_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
